### rtl/esftc_pkg.sv
package esftc_pkg;

    localparam int KEY_W      = 16;
    localparam int COEF_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [KEY_W-1:0]  KEY_RST    = 16'd256;
    localparam logic [COEF_W-1:0] COEF_A_RST = 24'd164495;
    localparam logic [COEF_W-1:0] COEF_B_RST = 24'd1966;
    localparam logic [COEF_W-1:0] COEF_C_RST = 24'd159252;
    localparam logic [COEF_W-1:0] COEF_D_RST = 24'd38666;
    localparam logic [COEF_W-1:0] COEF_E_RST = 24'd9175;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_SCALE = 3'd0,
        CFG_COEF_A    = 3'd1,
        CFG_COEF_B    = 3'd2,
        CFG_COEF_C    = 3'd3,
        CFG_COEF_D    = 3'd4,
        CFG_COEF_E    = 3'd5
    } t_cfg_idx;

    // per-sample control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic pos;
        logic clip;
        logic bad;
        logic neg;
        logic ovf;
    } t_ctl;

endpackage

### rtl/exposure_scaled_filmic_tone_curve.sv
// Filmic tone curve with exposure gain. Takes one sample per clock and
// returns one per clock unless stalled. The pipeline holds seven stages
// for the gain and the polynomial products, one overflow check, one
// divider cell per quotient bit (SAMPLE_BITS + 1 cells) and the rounding /
// output register. A stall on the output freezes the whole pipeline, so
// o_stall follows i_stall while a result is held. Coefficients are read
// live by the pipeline: write them only when no samples are in flight.
module exposure_scaled_filmic_tone_curve
    import esftc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int SAMPLE_FRAC_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_frame_last_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_frame_last_out,
    output logic                          o_clipped,
    input  logic                          i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = SAMPLE_FRAC_BITS;
    localparam int PW  = S + KEY_W + 1;
    localparam int VS  = PW + 1 - 8;
    localparam int MW  = COEF_W + VS;
    localparam int BW  = COEF_W + F;
    localparam int TW  = ((MW > BW) ? MW : BW) + 1;
    localparam int NW  = TW + VS;
    localparam int EW  = COEF_W + 2 * F;
    localparam int DW  = ((NW > EW) ? NW : EW) + 1;
    localparam int DNW = DW - 1;
    localparam int XW  = NW + F;
    localparam int QB  = S + 1;
    localparam int WW  = ((XW > DNW + QB) ? XW : DNW + QB) + 1;

    logic [KEY_W-1:0]  r_key;
    logic [COEF_W-1:0] r_ca, r_cb, r_cc, r_cd, r_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_RST;
            r_ca  <= COEF_A_RST;
            r_cb  <= COEF_B_RST;
            r_cc  <= COEF_C_RST;
            r_cd  <= COEF_D_RST;
            r_ce  <= COEF_E_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_SCALE: r_key <= i_cfg_data[KEY_W-1:0];
                CFG_COEF_A:    r_ca  <= i_cfg_data;
                CFG_COEF_B:    r_cb  <= i_cfg_data;
                CFG_COEF_C:    r_cc  <= i_cfg_data;
                CFG_COEF_D:    r_cd  <= i_cfg_data;
                CFG_COEF_E:    r_ce  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_ctl  r_oc;
    logic  en;
    assign en      = !r_oc.valid || !i_stall;
    assign o_stall = !en;

    t_ctl           f_ctl;
    logic [XW-1:0]  f_x;
    logic [DNW-1:0] f_den;
    logic [S-1:0]   f_pass;

    esftc_front #(
        .SAMPLE_BITS      (S),
        .SAMPLE_FRAC_BITS (F),
        .XW               (XW),
        .DNW              (DNW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_sample (i_sample_in),
        .i_last   (i_frame_last_in),
        .i_key    (r_key),
        .i_coef_a ($signed(r_ca)),
        .i_coef_b ($signed(r_cb)),
        .i_coef_c ($signed(r_cc)),
        .i_coef_d ($signed(r_cd)),
        .i_coef_e ($signed(r_ce)),
        .o_ctl    (f_ctl),
        .o_x      (f_x),
        .o_den    (f_den),
        .o_pass   (f_pass)
    );

    // quotient overflow check ahead of the divider chain
    t_ctl           r_pc;
    logic [WW-1:0]  r_prem;
    logic [DNW-1:0] r_pden;
    logic [S-1:0]   r_ppass;
    t_ctl           n_pc;

    always_comb begin
        n_pc     = f_ctl;
        n_pc.ovf = WW'(f_x) >= (WW'(f_den) << QB);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (en) begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prem  <= WW'(f_x);
            r_pden  <= f_den;
            r_ppass <= f_pass;
        end
    end

    t_ctl           c_ctl  [QB+1];
    logic [WW-1:0]  c_rem  [QB+1];
    logic [DNW-1:0] c_den  [QB+1];
    logic [QB-1:0]  c_quo  [QB+1];
    logic [S-1:0]   c_pass [QB+1];

    assign c_ctl[0]  = r_pc;
    assign c_rem[0]  = r_prem;
    assign c_den[0]  = r_pden;
    assign c_quo[0]  = '0;
    assign c_pass[0] = r_ppass;

    for (genvar g = 0; g < QB; g++) begin : g_cell
        esftc_div_cell #(
            .WW  (WW),
            .DNW (DNW),
            .QB  (QB),
            .K   (QB - 1 - g),
            .SW  (S)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[g]),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_quo   (c_quo[g]),
            .i_pass  (c_pass[g]),
            .o_ctl   (c_ctl[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_pass  (c_pass[g+1])
        );
    end

    // round half away from zero, then saturate; non-positive gained samples bypass the curve
    t_ctl         d_ctl;
    logic         n_rnd;
    logic [QB:0]  n_q;
    logic [S-1:0] n_res;
    logic         n_clip;
    logic [S-1:0] r_res;
    logic         r_clip;

    localparam logic [QB:0]  QMAX = (QB + 1)'((1 << (S - 1)) - 1);
    localparam logic [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};

    assign d_ctl = c_ctl[QB];

    always_comb begin
        n_rnd = ({1'b0, c_rem[QB]} << 1) >= (WW + 1)'(c_den[QB]);
        n_q   = (QB + 1)'(c_quo[QB]) + (QB + 1)'(n_rnd);
        priority if (!d_ctl.pos) begin
            n_res  = c_pass[QB];
            n_clip = d_ctl.clip;
        end else if (d_ctl.bad) begin
            n_res  = SMAX;
            n_clip = 1'b1;
        end else if (!d_ctl.neg) begin
            n_clip = d_ctl.ovf || (n_q > QMAX);
            n_res  = n_clip ? SMAX : n_q[S-1:0];
        end else begin
            n_clip = d_ctl.ovf || (n_q > QMAX + (QB + 1)'(1));
            n_res  = n_clip ? SMIN : S'(-n_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc <= '0;
        end else if (en) begin
            r_oc <= d_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res  <= n_res;
            r_clip <= n_clip;
        end
    end

    assign o_valid          = r_oc.valid;
    assign o_sample_out     = $signed(r_res);
    assign o_frame_last_out = r_oc.last;
    assign o_clipped        = r_clip;

endmodule

### rtl/esftc_front.sv
module esftc_front
    import esftc_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int SAMPLE_FRAC_BITS = 12,
    parameter int XW               = 87,
    parameter int DNW              = 75
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    input  logic                                   i_last,
    input  logic        [KEY_W-1:0]                i_key,
    input  logic signed [COEF_W-1:0]               i_coef_a,
    input  logic signed [COEF_W-1:0]               i_coef_b,
    input  logic signed [COEF_W-1:0]               i_coef_c,
    input  logic signed [COEF_W-1:0]               i_coef_d,
    input  logic signed [COEF_W-1:0]               i_coef_e,
    output t_ctl                                   o_ctl,
    output logic        [XW-1:0]                   o_x,
    output logic        [DNW-1:0]                  o_den,
    output logic        [SAMPLE_BITS-1:0]          o_pass
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = SAMPLE_FRAC_BITS;
    localparam int PW  = S + KEY_W + 1;
    localparam int VS  = PW + 1 - 8;
    localparam int MW  = COEF_W + VS;
    localparam int BW  = COEF_W + F;
    localparam int TW  = ((MW > BW) ? MW : BW) + 1;
    localparam int LW  = 24;
    localparam int HW  = TW - LW;
    localparam int PLW = LW + 1 + VS;
    localparam int PHW = HW + VS;
    localparam int NW  = TW + VS;
    localparam int EW  = COEF_W + 2 * F;
    localparam int DW  = ((NW > EW) ? NW : EW) + 1;

    t_ctl r_c1, r_c2, r_c3, r_c4, r_c5, r_c6, r_c7;
    logic [S-1:0] r_pass2, r_pass3, r_pass4, r_pass5, r_pass6, r_pass7;

    logic signed [PW-1:0]  r_p;
    logic signed [VS-1:0]  r_v2, r_v3, r_v4;
    logic signed [MW-1:0]  r_ma, r_mc;
    logic signed [TW-1:0]  r_ta, r_tc;
    logic signed [PLW-1:0] r_pal, r_pcl;
    logic signed [PHW-1:0] r_pah, r_pch;
    logic signed [NW-1:0]  r_n;
    logic signed [DW-1:0]  r_d;
    logic        [XW-1:0]  r_x;
    logic        [DNW-1:0] r_den;

    logic signed [PW:0]   n_pr;
    logic signed [VS-1:0] n_v;
    logic                 n_pos, n_nclip;
    logic [S-1:0]         n_pass;
    logic [NW-1:0]        n_mag;
    t_ctl                 n_c1, n_c2, n_c7;

    always_comb begin
        n_c1       = '0;
        n_c1.valid = i_valid;
        n_c1.last  = i_last;

        n_pr   = PW'(r_p) + (PW + 1)'(128);
        n_v    = n_pr[PW:8];
        n_pos  = !n_v[VS-1] && (n_v != '0);
        n_nclip = n_v[VS-1] && !(&n_v[VS-1:S-1]);
        n_pass = n_nclip ? {1'b1, {(S-1){1'b0}}} : n_v[S-1:0];
        n_c2      = r_c1;
        n_c2.pos  = n_pos;
        n_c2.clip = n_nclip;

        n_c7     = r_c6;
        n_c7.bad = r_d[DW-1] || (r_d == '0);
        n_c7.neg = r_n[NW-1];
        n_mag    = r_n[NW-1] ? NW'(-r_n) : NW'(r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
            r_c7 <= '0;
        end else if (i_en) begin
            r_c1 <= n_c1;
            r_c2 <= n_c2;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
            r_c5 <= r_c4;
            r_c6 <= r_c5;
            r_c7 <= n_c7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= PW'(i_sample * $signed({1'b0, i_key}));
            r_v2    <= n_v;
            r_pass2 <= n_pass;
            r_ma    <= MW'(i_coef_a * r_v2);
            r_mc    <= MW'(i_coef_c * r_v2);
            r_v3    <= r_v2;
            r_pass3 <= r_pass2;
            r_ta    <= TW'(r_ma) + (TW'(i_coef_b) <<< F);
            r_tc    <= TW'(r_mc) + (TW'(i_coef_d) <<< F);
            r_v4    <= r_v3;
            r_pass4 <= r_pass3;
            r_pal   <= PLW'($signed({1'b0, r_ta[LW-1:0]}) * r_v4);
            r_pah   <= PHW'($signed(r_ta[TW-1:LW]) * r_v4);
            r_pcl   <= PLW'($signed({1'b0, r_tc[LW-1:0]}) * r_v4);
            r_pch   <= PHW'($signed(r_tc[TW-1:LW]) * r_v4);
            r_pass5 <= r_pass4;
            r_n     <= (NW'(r_pah) <<< LW) + NW'(r_pal);
            r_d     <= (DW'(r_pch) <<< LW) + DW'(r_pcl) + (DW'(i_coef_e) <<< (2 * F));
            r_pass6 <= r_pass5;
            r_x     <= {n_mag, {F{1'b0}}};
            r_den   <= r_d[DNW-1:0];
            r_pass7 <= r_pass6;
        end
    end

    assign o_ctl  = r_c7;
    assign o_x    = r_x;
    assign o_den  = r_den;
    assign o_pass = r_pass7;

endmodule

### rtl/esftc_div_cell.sv
module esftc_div_cell
    import esftc_pkg::*;
#(
    parameter int WW  = 93,
    parameter int DNW = 75,
    parameter int QB  = 17,
    parameter int K   = 0,
    parameter int SW  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_ctl           i_ctl,
    input  logic [WW-1:0]  i_rem,
    input  logic [DNW-1:0] i_den,
    input  logic [QB-1:0]  i_quo,
    input  logic [SW-1:0]  i_pass,
    output t_ctl           o_ctl,
    output logic [WW-1:0]  o_rem,
    output logic [DNW-1:0] o_den,
    output logic [QB-1:0]  o_quo,
    output logic [SW-1:0]  o_pass
);

    t_ctl           r_ctl;
    logic [WW-1:0]  r_rem;
    logic [DNW-1:0] r_den;
    logic [QB-1:0]  r_quo;
    logic [SW-1:0]  r_pass;
    logic [WW:0]    n_trial;
    logic [QB-1:0]  n_quo;
    logic [WW-1:0]  n_rem;

    always_comb begin
        n_trial = {1'b0, i_rem} - ((WW + 1)'(i_den) << K);
        n_quo   = i_quo;
        n_rem   = i_rem;
        if (!n_trial[WW]) begin
            n_quo[K] = 1'b1;
            n_rem    = n_trial[WW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quo  <= n_quo;
            r_pass <= i_pass;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;
    assign o_pass = r_pass;

endmodule
